FILE: rtl/core/pixel_op_alu_u8_assert.svh
// ----------------------------------------------------------------------------
// pixel_op_alu_u8 assertion macros
// shared wrappers for the concurrent checks on the pixel alu ports
// ----------------------------------------------------------------------------
`ifndef PIXEL_OP_ALU_U8_ASSERT_SVH
`define PIXEL_OP_ALU_U8_ASSERT_SVH

// check that is switched off while reset is high
`define POA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds across reset
`define POA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/poa_pkg.sv
// ----------------------------------------------------------------------------
// poa_pkg
// types, widths and operation codes of the per-pixel 8-bit alu
// ----------------------------------------------------------------------------
`default_nettype none

package poa_pkg;

   localparam int PIXEL_W   = 8;
   localparam int LUT_DEPTH = 256;
   localparam int OP_W      = 5;
   localparam int CONST_W   = 9;
   localparam int WEIGHT_W  = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   // transaction kinds on the request channel
   localparam logic OPC_PIXEL       = 1'b0;
   localparam logic OPC_TABLE_WRITE = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OPERATION    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_VALUE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT = 2'd2;

   // operation codes
   localparam logic [OP_W-1:0] OP_SET    = 5'd0;
   localparam logic [OP_W-1:0] OP_NOT    = 5'd1;
   localparam logic [OP_W-1:0] OP_FLIP   = 5'd2;
   localparam logic [OP_W-1:0] OP_LUT    = 5'd3;
   localparam logic [OP_W-1:0] OP_ABS    = 5'd4;
   localparam logic [OP_W-1:0] OP_ADDC   = 5'd5;
   localparam logic [OP_W-1:0] OP_LERPC  = 5'd6;
   localparam logic [OP_W-1:0] OP_LERPNC = 5'd7;
   localparam logic [OP_W-1:0] OP_ADD    = 5'd8;
   localparam logic [OP_W-1:0] OP_AVG    = 5'd9;
   localparam logic [OP_W-1:0] OP_SUB    = 5'd10;
   localparam logic [OP_W-1:0] OP_SUBH   = 5'd11;
   localparam logic [OP_W-1:0] OP_SUBA   = 5'd12;
   localparam logic [OP_W-1:0] OP_LERP   = 5'd13;
   localparam logic [OP_W-1:0] OP_LERPN  = 5'd14;
   localparam logic [OP_W-1:0] OP_LERPI  = 5'd15;
   localparam logic [OP_W-1:0] OP_NORM   = 5'd16;

   localparam logic [OP_W-1:0] OP_RESET  = OP_NOT;

   typedef struct packed {
      logic        [OP_W-1:0]     operation;
      logic signed [CONST_W-1:0]  const_value;
      logic        [WEIGHT_W-1:0] blend_weight;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/core/poa_if.sv
// ----------------------------------------------------------------------------
// poa channel interfaces
// valid/ready channels for requests, responses and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface poa_req_if;
   import poa_pkg::*;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic [PIXEL_W-1:0] pixel_a;
   logic [PIXEL_W-1:0] pixel_b;
   logic [PIXEL_W-1:0] table_index;
   logic [PIXEL_W-1:0] table_value;

   modport source (output valid, opcode, pixel_a, pixel_b, table_index, table_value,
                   input ready);
   modport sink   (input valid, opcode, pixel_a, pixel_b, table_index, table_value,
                   output ready);
endinterface

interface poa_rsp_if;
   import poa_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] result_pixel;

   modport source (output valid, result_pixel, input ready);
   modport sink   (input valid, result_pixel, output ready);
endinterface

interface poa_csr_if;
   import poa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/poa_ram.sv
// ----------------------------------------------------------------------------
// poa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module poa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/poa_alu.sv
// ----------------------------------------------------------------------------
// poa_alu
// combinational datapath of the pixel alu, one result per operand pair
// ----------------------------------------------------------------------------
`default_nettype none

module poa_alu (
   input  poa_pkg::cfg_type                cfg,
   input  logic [poa_pkg::PIXEL_W-1:0]     pixel_a,
   input  logic [poa_pkg::PIXEL_W-1:0]     pixel_b,
   input  logic [poa_pkg::PIXEL_W-1:0]     lut_data,
   output logic [poa_pkg::PIXEL_W-1:0]     result
);
   import poa_pkg::*;

   // min(2*|v-128|, 255)
   function automatic logic [PIXEL_W-1:0] abs_biased(input logic [PIXEL_W-1:0] v);
      logic [PIXEL_W-1:0] mag;
      logic [PIXEL_W:0]   twice;
      begin
         mag   = v[PIXEL_W-1] ? (v - 8'h80) : (8'h80 - v);
         twice = {mag, 1'b0};
         abs_biased = twice[PIXEL_W] ? 8'hff : twice[PIXEL_W-1:0];
      end
   endfunction

   logic [PIXEL_W-1:0]        c_byte;
   logic [PIXEL_W-1:0]        abs_a;
   logic [PIXEL_W-1:0]        abs_b;
   logic signed [9:0]         addc_sum;
   logic [PIXEL_W-1:0]        addc_res;
   logic [PIXEL_W:0]          sum9;
   logic [PIXEL_W+1:0]        avg10;
   logic [PIXEL_W:0]          dif9;
   logic [PIXEL_W-1:0]        neg_dif;
   logic [PIXEL_W+1:0]        norm10;
   logic [PIXEL_W-1:0]        target;
   logic                      away;
   logic signed [9:0]         diff;
   logic signed [9:0]         weight_s;
   logic signed [19:0]        prod;
   logic signed [19:0]        bias;
   logic signed [19:0]        blend_sum;
   logic [PIXEL_W-1:0]        blend_res;

   assign c_byte = cfg.const_value[PIXEL_W-1:0];
   assign abs_a  = abs_biased(pixel_a);
   assign abs_b  = abs_biased(pixel_b);

   // saturating add of the signed constant
   assign addc_sum = $signed({2'b00, pixel_a}) +
                     $signed({cfg.const_value[CONST_W-1], cfg.const_value});
   always_comb begin
      if (addc_sum[9]) begin
         addc_res = 8'h00;
      end else if (addc_sum[8]) begin
         addc_res = 8'hff;
      end else begin
         addc_res = addc_sum[PIXEL_W-1:0];
      end
   end

   assign sum9    = {1'b0, pixel_a} + {1'b0, pixel_b};
   assign avg10   = {1'b0, sum9} + 10'd1;
   assign dif9    = {1'b0, pixel_a} - {1'b0, pixel_b};
   assign neg_dif = pixel_b - pixel_a;
   assign norm10  = {2'b00, abs_a} + {2'b00, abs_b} + 10'd1;

   // blend target and rounding
   always_comb begin
      case (cfg.operation)
         OP_LERPC, OP_LERPNC: begin
            target = c_byte;
         end
         OP_LERPI: begin
            target = ~pixel_b;
         end
         default: begin
            target = pixel_b;
         end
      endcase
   end

   assign away      = (cfg.operation == OP_LERPNC) || (cfg.operation == OP_LERPN);
   assign diff      = $signed({2'b00, target}) - $signed({2'b00, pixel_a});
   assign weight_s  = $signed({1'b0, cfg.blend_weight});
   assign prod      = 20'(diff) * 20'(weight_s);
   assign bias      = away ? (prod[19] ? 20'sd0 : 20'sd255) : 20'sd128;
   assign blend_sum = prod + bias;
   // floor division by 256 keeps only bits 15:8 after the 8-bit truncation
   assign blend_res = pixel_a + blend_sum[15:8];

   always_comb begin
      case (cfg.operation)
         OP_SET:    result = c_byte;
         OP_NOT:    result = ~pixel_a;
         OP_FLIP:   result = pixel_a ^ 8'h80;
         OP_LUT:    result = lut_data;
         OP_ABS:    result = abs_a;
         OP_ADDC:   result = addc_res;
         OP_LERPC:  result = blend_res;
         OP_LERPNC: result = blend_res;
         OP_ADD:    result = sum9[PIXEL_W] ? 8'hff : sum9[PIXEL_W-1:0];
         OP_AVG:    result = avg10[PIXEL_W:1];
         OP_SUB:    result = dif9[PIXEL_W] ? 8'h00 : dif9[PIXEL_W-1:0];
         OP_SUBH:   result = {~dif9[PIXEL_W], dif9[PIXEL_W-1:1]};
         OP_SUBA:   result = dif9[PIXEL_W] ? neg_dif : dif9[PIXEL_W-1:0];
         OP_LERP:   result = blend_res;
         OP_LERPN:  result = blend_res;
         OP_LERPI:  result = blend_res;
         OP_NORM:   result = norm10[PIXEL_W:1];
         default:   result = pixel_a;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/pixel_op_alu_u8.sv
// ----------------------------------------------------------------------------
// pixel_op_alu_u8
// per-pixel 8-bit alu with a 256-entry lookup table and three settings
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    opcode, pixel_a, pixel_b, table_index, table_value
//   rsp_bus   out   valid/ready    result_pixel
//   csr_bus   in    valid/ready    index, data (always ready)
//
// two register stages: the request stage (operands plus lookup table read)
// and the response register; a pixel transaction's result passes through the
// request stage and then the response register, and one transaction is taken
// every cycle unless a stalled response holds a full request stage
// a table write is done in the cycle it is taken and gives no response
// reset clears the valid flags and loads the settings; table contents stay
// undefined until written
// a stalled response holds both stages; the request stage still takes a
// transaction whenever it is empty or moving on
`default_nettype none

module pixel_op_alu_u8 (
   input  logic     clock,
   input  logic     reset,
   poa_req_if.sink   req_bus,
   poa_rsp_if.source rsp_bus,
   poa_csr_if.sink   csr_bus
);
   import poa_pkg::*;

   // settings
   cfg_type cfg_ff, cfg_in;

   // request stage
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_a_ff, s1_a_in;
   logic [PIXEL_W-1:0] s1_b_ff, s1_b_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;

   logic               req_fire;
   logic               pixel_fire;
   logic               table_fire;
   logic               rsp_advance;
   logic [PIXEL_W-1:0] lut_data;
   logic [PIXEL_W-1:0] alu_result;

   // response register frees up when empty or being taken
   assign rsp_advance   = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || rsp_advance;

   assign req_fire   = req_bus.valid && req_bus.ready;
   assign pixel_fire = req_fire && (req_bus.opcode == OPC_PIXEL);
   assign table_fire = req_fire && (req_bus.opcode == OPC_TABLE_WRITE);

   // settings write port, never stalls
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_OPERATION: begin
               cfg_in.operation = csr_bus.data[OP_W-1:0];
            end
            CSR_CONST_VALUE: begin
               cfg_in.const_value = $signed(csr_bus.data[CONST_W-1:0]);
            end
            CSR_BLEND_WEIGHT: begin
               cfg_in.blend_weight = csr_bus.data[WEIGHT_W-1:0];
            end
            default: begin
               // writes past the register list are dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // lookup table: written by table transactions, read at pixel_a on entry
   poa_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (LUT_DEPTH)
   ) u_lut (
      .clock   (clock),
      .wr_en   (table_fire),
      .wr_addr (req_bus.table_index),
      .wr_data (req_bus.table_value),
      .rd_en   (pixel_fire),
      .rd_addr (req_bus.pixel_a),
      .rd_data (lut_data)
   );

   // request stage: only pixel transactions occupy it
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_a_in     = s1_a_ff;
      s1_b_in     = s1_b_ff;
      if (req_bus.ready) begin
         s1_valid_in = pixel_fire;
      end
      if (pixel_fire) begin
         s1_a_in = req_bus.pixel_a;
         s1_b_in = req_bus.pixel_b;
      end
   end

   poa_alu u_alu (
      .cfg      (cfg_ff),
      .pixel_a  (s1_a_ff),
      .pixel_b  (s1_b_ff),
      .lut_data (lut_data),
      .result   (alu_result)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (rsp_advance) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_pixel_in = alu_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.operation    <= OP_RESET;
         cfg_ff.const_value  <= '0;
         cfg_ff.blend_weight <= '0;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_a_ff      <= s1_a_in;
      s1_b_ff      <= s1_b_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_pixel = rsp_pixel_ff;

endmodule

`default_nettype wire

FILE: rtl/core/poa_checker.sv
// ----------------------------------------------------------------------------
// poa_checker
// port-level checks on the pixel alu, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "pixel_op_alu_u8_assert.svh"

module poa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_opcode,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [poa_pkg::PIXEL_W-1:0]  rsp_pixel
);
   import poa_pkg::*;

   // a response held back keeps its valid
   `POA_ASSERT(a_rsp_valid_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // a response held back keeps its pixel
   `POA_ASSERT(a_rsp_data_hold, rsp_valid && !rsp_ready |=> $stable(rsp_pixel), "response pixel changed while stalled")

   // a new response comes only from an earlier pixel transaction that passed through the request stage
   `POA_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_opcode == OPC_PIXEL), 2), "response without a pixel transaction")

   // reset empties the response register
   `POA_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind pixel_op_alu_u8 poa_checker u_poa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_opcode (req_bus.opcode),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_pixel  (rsp_bus.result_pixel)
);

`default_nettype wire
